// ===== sv/pwfs_pkg.sv =====
// Package for the protobuf wire field scanner.
// Holds the request/response payload types, the queue entry type and shared codes.
// No dependencies.
package pwfs_pkg;

   // Default width of the message byte counter
   localparam int DEFAULT_OFFSET_BITS = 32;

   // Request queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Field widths
   localparam int FIELD_NUM_W = 29;
   localparam int WIRE_TYPE_W = 3;
   localparam int STATUS_W    = 3;
   localparam int VALUE_W     = 64;
   localparam int POS_W       = 32;
   localparam int SHIFT_W     = 7;

   // Varint length limits, as accumulated shift
   localparam logic [SHIFT_W-1:0] SHORT_VARINT_LIMIT = 7'd35;
   localparam logic [SHIFT_W-1:0] LONG_VARINT_LIMIT  = 7'd70;
   localparam logic [SHIFT_W-1:0] VARINT_STEP        = 7'd7;
   localparam logic [SHIFT_W-1:0] FIXED_STEP         = 7'd8;

   // Fixed value byte counts
   localparam logic [POS_W-1:0] FIXED64_BYTES = 32'd8;
   localparam logic [POS_W-1:0] FIXED32_BYTES = 32'd4;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_FIELD    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ZERO_TAG = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BUF_END  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_WT   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_TRUNC    = 3'd4;
   localparam logic [STATUS_W-1:0] ST_OVERLONG = 3'd5;

   // Wire types
   localparam logic [WIRE_TYPE_W-1:0] WT_VARINT  = 3'd0;
   localparam logic [WIRE_TYPE_W-1:0] WT_FIXED64 = 3'd1;
   localparam logic [WIRE_TYPE_W-1:0] WT_LENGTH  = 3'd2;
   localparam logic [WIRE_TYPE_W-1:0] WT_FIXED32 = 3'd5;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic [FIELD_NUM_W-1:0] field_num;
      logic [WIRE_TYPE_W-1:0] wire_kind;
      logic [VALUE_W-1:0]     value;
      logic [POS_W-1:0]       payload_offset;
      logic [POS_W-1:0]       payload_length;
      logic                   message_end;
   } rsp_type;

   // Classified byte as held in the queue
   typedef struct packed {
      logic [7:0] data_byte;
      logic [6:0] low7;
      logic       cont;
      logic       last_byte;
   } entry_type;

endpackage

// ===== sv/pwfs_front.sv =====
// Front of the scanner: accepts request bytes, classifies them and queues them.
// Depends on pwfs_pkg.
module pwfs_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  pwfs_pkg::req_type  req_data,
   input  logic               q_pop,
   output logic               q_valid,
   output pwfs_pkg::entry_type q_entry
);
   import pwfs_pkg::*;

   entry_type               mem_ff [QUEUE_DEPTH];
   logic [QUEUE_IDX_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_IDX_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]  count_ff, count_in;
   logic                    push;
   entry_type               push_entry;

   // Full queue stalls the request side
   assign req_stall = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign q_entry   = mem_ff[rd_ptr_ff];

   // Byte classification
   always_comb begin
      push_entry.data_byte = req_data.data_byte;
      push_entry.low7      = req_data.data_byte[6:0];
      push_entry.cont      = req_data.data_byte[7];
      push_entry.last_byte = req_data.last_byte;
   end

   // Pointer and count update
   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("queue count above depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> count_ff != '0)
      else $error("pop from empty queue");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !q_pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count lost a push");

endmodule

// ===== sv/pwfs_back.sv =====
// Back of the scanner: decodes queued bytes into tags, values and payload spans,
// and holds the result in an output register. Depends on pwfs_pkg.
module pwfs_back #(
   parameter int OFFSET_BITS = pwfs_pkg::DEFAULT_OFFSET_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  pwfs_pkg::entry_type q_entry,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output pwfs_pkg::rsp_type   rsp_data
);
   import pwfs_pkg::*;

   typedef enum logic [2:0] {
      PH_TAG,
      PH_VARINT,
      PH_FIXED,
      PH_LENGTH,
      PH_PAYLOAD,
      PH_IDLE
   } phase_type;

   phase_type               phase_ff, phase_in;
   logic [SHIFT_W-1:0]      shift_ff, shift_in;
   logic [VALUE_W-1:0]      acc_ff, acc_in;
   logic [FIELD_NUM_W-1:0]  fnum_ff, fnum_in;
   logic [WIRE_TYPE_W-1:0]  wtype_ff, wtype_in;
   logic [OFFSET_BITS-1:0]  offset_ff, offset_in;
   logic [POS_W-1:0]        remain_ff, remain_in;
   logic [OFFSET_BITS-1:0]  pstart_ff, pstart_in;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_data_ff;

   logic                    out_free;
   logic                    have;
   logic                    emit;
   logic [STATUS_W-1:0]     st;
   logic [VALUE_W-1:0]      val;
   logic [POS_W-1:0]        poff;
   logic [POS_W-1:0]        plen;
   logic [SHIFT_W-1:0]      limit;
   logic [VALUE_W-1:0]      part7;
   logic [VALUE_W-1:0]      part8;
   logic [POS_W-1:0]        remain_dec;
   rsp_type                 result;

   // Output register frees when empty or being taken
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign q_pop     = q_valid && out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Shifted byte contributions; nothing lands at shift 64 or beyond
   always_comb begin
      part7 = shift_ff[SHIFT_W-1] ? '0
            : ({57'b0, q_entry.low7} << shift_ff[SHIFT_W-2:0]);
      part8 = shift_ff[SHIFT_W-1] ? '0
            : ({56'b0, q_entry.data_byte} << shift_ff[SHIFT_W-2:0]);
      remain_dec = (remain_ff != '0) ? remain_ff - 1'b1 : remain_ff;
   end

   // Per-byte decode
   always_comb begin
      phase_in  = phase_ff;
      shift_in  = shift_ff;
      acc_in    = acc_ff;
      fnum_in   = fnum_ff;
      wtype_in  = wtype_ff;
      offset_in = offset_ff;
      remain_in = remain_ff;
      pstart_in = pstart_ff;
      have      = 1'b0;
      emit      = 1'b0;
      st        = ST_FIELD;
      val       = '0;
      poff      = '0;
      plen      = '0;
      limit     = (phase_ff == PH_VARINT) ? LONG_VARINT_LIMIT : SHORT_VARINT_LIMIT;

      if (phase_ff == PH_IDLE) begin
         // Skip until the buffer's last byte
         if (q_entry.last_byte) begin
            phase_in  = PH_TAG;
            offset_in = '0;
         end
      end else begin
         offset_in = offset_ff + 1'b1;
         unique case (phase_ff)
            PH_TAG, PH_VARINT, PH_LENGTH: begin
               if (phase_ff == PH_TAG && shift_ff == '0) begin
                  fnum_in  = '0;
                  wtype_in = '0;
               end
               acc_in = acc_ff | part7;
               if (q_entry.cont) begin
                  shift_in = shift_ff + VARINT_STEP;
                  if (shift_in >= limit) begin
                     have = 1'b1;
                     st   = ST_OVERLONG;
                  end
               end else if (phase_ff != PH_VARINT && acc_in[VALUE_W-1:POS_W] != '0) begin
                  have = 1'b1;
                  st   = ST_OVERLONG;
               end else if (phase_ff == PH_VARINT) begin
                  have = 1'b1;
                  val  = acc_in;
               end else if (phase_ff == PH_LENGTH) begin
                  pstart_in = offset_ff + 1'b1;
                  remain_in = acc_in[POS_W-1:0];
                  if (remain_in == '0) begin
                     have = 1'b1;
                     poff = POS_W'(pstart_in);
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end else if (acc_in == '0) begin
                  have = 1'b1;
                  st   = ST_ZERO_TAG;
               end else begin
                  // Tag complete: split into field number and wire type
                  fnum_in  = acc_in[FIELD_NUM_W+WIRE_TYPE_W-1:WIRE_TYPE_W];
                  wtype_in = acc_in[WIRE_TYPE_W-1:0];
                  shift_in = '0;
                  acc_in   = '0;
                  unique case (wtype_in)
                     WT_VARINT:  phase_in = PH_VARINT;
                     WT_LENGTH:  phase_in = PH_LENGTH;
                     WT_FIXED64: begin
                        phase_in  = PH_FIXED;
                        remain_in = FIXED64_BYTES;
                     end
                     WT_FIXED32: begin
                        phase_in  = PH_FIXED;
                        remain_in = FIXED32_BYTES;
                     end
                     default: begin
                        have = 1'b1;
                        st   = ST_BAD_WT;
                     end
                  endcase
               end
            end
            PH_FIXED: begin
               acc_in    = acc_ff | part8;
               shift_in  = shift_ff + FIXED_STEP;
               remain_in = remain_dec;
               if (remain_dec == '0) begin
                  have = 1'b1;
                  val  = acc_in;
               end
            end
            PH_PAYLOAD: begin
               remain_in = remain_dec;
               if (remain_dec == '0) begin
                  have = 1'b1;
                  poff = POS_W'(pstart_ff);
                  plen = acc_ff[POS_W-1:0];
               end
            end
            default: begin
               phase_in = PH_TAG;
            end
         endcase

         // Close out an item, an error or the buffer
         if (have || q_entry.last_byte) begin
            emit = 1'b1;
            if (!have) begin
               st = ST_TRUNC;
            end
            if (st != ST_FIELD) begin
               val  = '0;
               poff = '0;
               plen = '0;
            end
            if (st == ST_FIELD && q_entry.last_byte) begin
               st = ST_BUF_END;
            end
            if (q_entry.last_byte) begin
               phase_in  = PH_TAG;
               offset_in = '0;
            end else if (st != ST_FIELD) begin
               phase_in = PH_IDLE;
            end else begin
               phase_in = PH_TAG;
            end
            shift_in = '0;
            acc_in   = '0;
         end
      end

      result.status         = st;
      result.field_num      = fnum_in;
      result.wire_kind      = wtype_in;
      result.value          = val;
      result.payload_offset = poff;
      result.payload_length = plen;
      result.message_end    = (st != ST_FIELD);
   end

   // Decoder state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_TAG;
         shift_ff     <= '0;
         acc_ff       <= '0;
         fnum_ff      <= '0;
         wtype_ff     <= '0;
         offset_ff    <= '0;
         remain_ff    <= '0;
         pstart_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            phase_ff  <= phase_in;
            shift_ff  <= shift_in;
            acc_ff    <= acc_in;
            fnum_ff   <= fnum_in;
            wtype_ff  <= wtype_in;
            offset_ff <= offset_in;
            remain_ff <= remain_in;
            pstart_ff <= pstart_in;
         end
         if (out_free) begin
            rsp_valid_ff <= q_pop && emit;
         end
      end
      if (q_pop && emit) begin
         rsp_data_ff <= result;
      end
   end

   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      (q_pop && phase_ff == PH_IDLE) |=> !rsp_valid_ff)
      else $error("result emitted while skipping to buffer end");

   a_end_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.message_end == (rsp_data_ff.status != ST_FIELD)))
      else $error("message_end disagrees with status");

   a_shift_bound: assert property (@(posedge clock) disable iff (reset)
      shift_ff <= LONG_VARINT_LIMIT)
      else $error("varint shift out of range");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status != ST_FIELD && rsp_data_ff.status != ST_BUF_END)
      |-> (rsp_data_ff.value == '0 && rsp_data_ff.payload_length == '0))
      else $error("error result carries a value");

endmodule

// ===== sv/protobuf_wire_field_scanner.sv =====
// Protobuf wire field scanner: one message byte per request, at most one field result each.
// Throughput: one byte per cycle; a response stall pauses the decoder while the queue fills.
// Path: the byte that completes a result is written into the queue when accepted, and the
// decoder pops it from there and registers the result in the output register.
// Reset: synchronous, active high; clears queue, decoder state and output valid.
// Depends on pwfs_pkg, pwfs_front, pwfs_back.
module protobuf_wire_field_scanner #(
   parameter int OFFSET_BITS = pwfs_pkg::DEFAULT_OFFSET_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pwfs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pwfs_pkg::rsp_type rsp_data
);
   import pwfs_pkg::*;

   logic      q_pop;
   logic      q_valid;
   entry_type q_entry;

   pwfs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_pop     (q_pop),
      .q_valid   (q_valid),
      .q_entry   (q_entry)
   );

   pwfs_back #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_entry   (q_entry),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
